// ===== rtl/core/c3pf_pkg.sv =====
// ----------------------------------------------------------------------------
// c3pf_pkg
// Shared constants, codes, kernel table and types for the 3x3 preset filter.
// ----------------------------------------------------------------------------
package c3pf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  // field widths of the register file and the item payloads
  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int MODE_W       = 3;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int PIX_W        = 8;

  // position counters
  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WEFF_W   = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HEFF_W   = $clog2(MAX_HEIGHT + 1);
  localparam int IN_ROW_W = HEFF_W + 1;  // input row runs up to H+1 while draining

  // arithmetic
  localparam int WEIGHT_W    = 5;
  localparam int SUM_W       = 13;
  localparam int BOX_X_W     = 12;
  localparam int BOX_RECIP_W = 12;
  localparam logic [BOX_RECIP_W-1:0] BOX_RECIP = 12'd3641;  // 2^15 / 9, rounded up
  localparam int BOX_SHIFT   = 15;
  localparam int PIX_MAX     = 255;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_MODE  = 2'd2;

  // kernel modes
  localparam logic [MODE_W-1:0] MODE_BOX     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GAUSS   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EMBOSS  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHARPEN = 3'd4;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // reset values of the registers
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;  // [row][column], column 2 newest

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  // travels with an item down the pipeline
  typedef struct packed {
    logic    valid;
    border_t border;
    logic    last;
  } tag_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } result_t;

  localparam weight_t K_BOX [9] = '{
    5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1, 5'sd1};
  localparam weight_t K_GAUSS [9] = '{
    5'sd1, 5'sd2, 5'sd1, 5'sd2, 5'sd4, 5'sd2, 5'sd1, 5'sd2, 5'sd1};
  localparam weight_t K_OUTLINE [9] = '{
    -5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1};
  localparam weight_t K_EMBOSS [9] = '{
    -5'sd2, -5'sd1, 5'sd0, -5'sd1, 5'sd1, 5'sd1, 5'sd0, 5'sd1, 5'sd2};
  localparam weight_t K_SHARPEN [9] = '{
    5'sd0, -5'sd1, 5'sd0, -5'sd1, 5'sd5, -5'sd1, 5'sd0, -5'sd1, 5'sd0};

  // idx = row * 3 + column
  function automatic weight_t kernel_weight(input logic [MODE_W-1:0] mode,
                                            input logic [3:0] idx);
    weight_t w;
    case (mode)
      MODE_GAUSS:   w = K_GAUSS[idx];
      MODE_OUTLINE: w = K_OUTLINE[idx];
      MODE_EMBOSS:  w = K_EMBOSS[idx];
      MODE_SHARPEN: w = K_SHARPEN[idx];
      default:      w = K_BOX[idx];
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/c3pf_in_if.sv =====
// ----------------------------------------------------------------------------
// c3pf_in_if
// Input item channel: opcode and pixel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface c3pf_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [c3pf_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output op, output pixel_in, input ready);
  modport sink (input valid, input op, input pixel_in, output ready);
endinterface

// ===== rtl/core/c3pf_out_if.sv =====
// ----------------------------------------------------------------------------
// c3pf_out_if
// Result item channel: filtered pixel and frame end flag with valid/ready.
// ----------------------------------------------------------------------------
interface c3pf_out_if;
  logic                        valid;
  logic                        ready;
  logic [c3pf_pkg::PIX_W-1:0]  pixel_out;
  logic                        frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== rtl/core/c3pf_ram.sv =====
// ----------------------------------------------------------------------------
// c3pf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module c3pf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/c3pf_ctrl.sv =====
// ----------------------------------------------------------------------------
// c3pf_ctrl
// Register file and frame position tracking; tags each accepted item with
// its emit flag, border masks and frame end flag.
// ----------------------------------------------------------------------------
module c3pf_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [c3pf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [c3pf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                accept,
  output logic [c3pf_pkg::COL_W-1:0]          col,
  output c3pf_pkg::tag_t                      tag,
  output logic [c3pf_pkg::MODE_W-1:0]         mode
);
  import c3pf_pkg::*;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [MODE_W-1:0]       kernel_mode;

  logic [WEFF_W-1:0]   w_eff;
  logic [HEFF_W-1:0]   h_eff;

  logic [COL_W-1:0]    in_column, in_column_next;
  logic [IN_ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0]    out_column, out_column_next;
  logic [ROW_W-1:0]    out_row, out_row_next;

  logic emit, last, in_wrap, out_wrap, col_end, row_end;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WEFF_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HEFF_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HEFF_W'(MAX_HEIGHT);
    end else begin
      h_eff = HEFF_W'(image_height);
    end
  end

  assign mode = (kernel_mode > MODE_SHARPEN) ? MODE_BOX : kernel_mode;

  // the item at linear position p yields the result for pixel p-W-1
  assign emit    = (in_row >= IN_ROW_W'(2)) || ((in_row == IN_ROW_W'(1)) && (in_column != '0));
  assign in_wrap = (32'(in_column) + 32'd1) >= 32'(w_eff);
  assign col_end = (32'(out_column) + 32'd1) >= 32'(w_eff);
  assign row_end = (32'(out_row) + 32'd1) >= 32'(h_eff);
  assign last    = row_end && col_end;
  assign out_wrap = col_end;

  assign col                = in_column;
  assign tag.valid          = emit;
  assign tag.border.top     = (out_row == '0);
  assign tag.border.bottom  = row_end;
  assign tag.border.left    = (out_column == '0);
  assign tag.border.right   = col_end;
  assign tag.last           = last;

  always_comb begin
    in_column_next  = in_column + COL_W'(1);
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (in_wrap) begin
      in_column_next = '0;
      in_row_next    = in_row + IN_ROW_W'(1);
    end
    if (emit) begin
      if (last) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
      end else if (out_wrap) begin
        out_column_next = '0;
        out_row_next    = out_row + ROW_W'(1);
      end else begin
        out_column_next = out_column + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      kernel_mode  <= MODE_BOX;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data[WIDTH_REG_W-1:0];
          in_column   <= '0;
          in_row      <= '0;
          out_column  <= '0;
          out_row     <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[HEIGHT_REG_W-1:0];
          in_column    <= '0;
          in_row       <= '0;
          out_column   <= '0;
          out_row      <= '0;
        end
        REG_KERNEL_MODE: begin
          kernel_mode <= cfg_data[MODE_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

endmodule

// ===== rtl/core/c3pf_window.sv =====
// ----------------------------------------------------------------------------
// c3pf_window
// Two line stores and the 3x3 window. Stage 1 waits for the line store read,
// then writes the column back and shifts the window.
// ----------------------------------------------------------------------------
module c3pf_window (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          accept,
  input  logic [c3pf_pkg::COL_W-1:0]    col,
  input  logic                          op,
  input  logic [c3pf_pkg::PIX_W-1:0]    pixel_in,
  input  c3pf_pkg::tag_t                tag_in,
  output c3pf_pkg::win_t                win,
  output c3pf_pkg::tag_t                tag_out
);
  import c3pf_pkg::*;

  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_pix;
  tag_t             s1_tag;

  logic [PIX_W-1:0] rd_upper, rd_lower;
  logic [PIX_W-1:0] top_eff, mid_eff;

  // bypass for a read that collides with the write of the previous item
  logic             fwd;
  logic [PIX_W-1:0] fwd_top, fwd_mid;

  win_t window;
  tag_t s2_tag;

  assign top_eff = fwd ? fwd_top : rd_upper;
  assign mid_eff = fwd ? fwd_mid : rd_lower;

  c3pf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (en && s1_valid),
    .waddr (s1_col),
    .wdata (mid_eff),
    .re    (en),
    .raddr (col),
    .rdata (rd_upper)
  );

  c3pf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_lower (
    .clk   (clk),
    .we    (en && s1_valid),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (en),
    .raddr (col),
    .rdata (rd_lower)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
      window   <= '0;
      s2_tag   <= '0;
    end else if (en) begin
      s1_valid <= accept;
      fwd      <= s1_valid && accept && (s1_col == col);
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          window[r][0] <= window[r][1];
          window[r][1] <= window[r][2];
        end
        window[0][2] <= top_eff;
        window[1][2] <= mid_eff;
        window[2][2] <= s1_pix;
      end
      s2_tag.valid  <= s1_valid && s1_tag.valid;
      s2_tag.border <= s1_tag.border;
      s2_tag.last   <= s1_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_top <= mid_eff;
      fwd_mid <= s1_pix;
      if (accept) begin
        s1_col <= col;
        s1_pix <= (op == OP_DRAIN) ? '0 : pixel_in;
        s1_tag <= tag_in;
      end
    end
  end

  assign win     = window;
  assign tag_out = s2_tag;

endmodule

// ===== rtl/core/c3pf_mac.sv =====
// ----------------------------------------------------------------------------
// c3pf_mac
// Masked weighted sum of the window (stage 2), then normalize and clamp
// (stage 3) into one result.
// ----------------------------------------------------------------------------
module c3pf_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  c3pf_pkg::win_t                win,
  input  c3pf_pkg::tag_t                tag_in,
  input  logic [c3pf_pkg::MODE_W-1:0]   mode,
  output c3pf_pkg::result_t             res
);
  import c3pf_pkg::*;

  logic signed [SUM_W-1:0] prod [9];
  logic signed [SUM_W-1:0] sum;

  logic signed [SUM_W-1:0] s3_sum;
  logic [MODE_W-1:0]       s3_mode;
  tag_t                    s3_tag;

  logic [BOX_X_W-1:0]                 box_x;
  logic [BOX_X_W+BOX_RECIP_W-1:0]     box_prod;
  logic signed [SUM_W-1:0]            val;

  always_comb begin
    logic             masked;
    logic [PIX_W-1:0] tap_pix;
    weight_t          w;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        masked = (r == 0 && tag_in.border.top) || (r == 2 && tag_in.border.bottom) ||
                 (c == 0 && tag_in.border.left) || (c == 2 && tag_in.border.right);
        tap_pix = masked ? '0 : win[r][c];
        w    = kernel_weight(mode, 4'(r * 3 + c));
        prod[r * 3 + c] = $signed({{(SUM_W - PIX_W){1'b0}}, tap_pix} *
                                  {{(SUM_W - WEIGHT_W){w[WEIGHT_W-1]}}, w});
      end
    end
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      sum = sum + prod[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_tag <= '0;
    end else if (en) begin
      s3_tag <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum  <= sum;
      s3_mode <= mode;
    end
  end

  // box: (sum+4)/9 by reciprocal, exact for the box sum range
  assign box_x    = BOX_X_W'($unsigned(s3_sum + SUM_W'(4)));
  assign box_prod = box_x * BOX_RECIP;

  always_comb begin
    case (s3_mode)
      MODE_BOX:     val = $signed(SUM_W'(box_prod >> BOX_SHIFT));
      MODE_GAUSS:   val = (s3_sum + SUM_W'(8)) >>> 4;
      MODE_OUTLINE: val = s3_sum;
      MODE_EMBOSS:  val = s3_sum;
      MODE_SHARPEN: val = s3_sum;
      default:      val = s3_sum;
    endcase
  end

  assign res.valid = s3_tag.valid;
  assign res.last  = s3_tag.last;
  assign res.pixel = (val < 0) ? '0 :
                     (val > SUM_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : val[PIX_W-1:0];

endmodule

// ===== rtl/core/conv3x3_preset_filter.sv =====
// ----------------------------------------------------------------------------
// conv3x3_preset_filter
// Streaming 3x3 convolution of 8-bit greyscale pixels with preset kernels.
// ----------------------------------------------------------------------------
// One item is accepted every clock while ready is high. The result for pixel
// k of a frame comes out with input item k+W+1 (W = image width), so after
// the last pixel the host sends W+1 drain items; from acceptance of that item
// the result reaches the output register through line store read, window and
// sum, normalize and clamp. The rate is set by the two MAX_WIDTH x 8 line
// stores, each read and written once per item. An output register plus a skid
// stage let input run on while one result waits; ready drops only when both
// are full. Line stores are not cleared after reset or a size change: border
// masking hides every entry the current frame has not written.
// ----------------------------------------------------------------------------
module conv3x3_preset_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [c3pf_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [c3pf_pkg::CFG_DATA_W-1:0]   cfg_data,
  c3pf_in_if.sink                           pixels,
  c3pf_out_if.source                        results
);
  import c3pf_pkg::*;

  logic             en, accept;
  logic [COL_W-1:0] col;
  tag_t             tag0, tag2;
  logic [MODE_W-1:0] mode;
  win_t             win;
  result_t          res;

  logic             out_valid, skid_valid;
  logic [PIX_W-1:0] out_pixel, skid_pixel;
  logic             out_last, skid_last;

  assign en           = !skid_valid;
  assign accept       = pixels.valid && en;
  assign pixels.ready = en;

  c3pf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .col       (col),
    .tag       (tag0),
    .mode      (mode)
  );

  c3pf_window u_window (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .accept   (accept),
    .col      (col),
    .op       (pixels.op),
    .pixel_in (pixels.pixel_in),
    .tag_in   (tag0),
    .win      (win),
    .tag_out  (tag2)
  );

  c3pf_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .win    (win),
    .tag_in (tag2),
    .mode   (mode),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (results.ready) begin
        out_pixel  <= skid_pixel;
        out_last   <= skid_last;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || results.ready) begin
      out_valid <= res.valid;
      out_pixel <= res.pixel;
      out_last  <= res.last;
    end else if (res.valid) begin
      skid_valid <= 1'b1;
      skid_pixel <= res.pixel;
      skid_last  <= res.last;
    end
  end

  assign results.valid      = out_valid;
  assign results.pixel_out  = out_pixel;
  assign results.frame_last = out_last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds an item while the output register is empty");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready && res.valid && !skid_valid) |=> skid_valid)
    else $error("result arrived at a stalled output and was not caught");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> ($past(out_valid) && !$past(results.ready)))
    else $error("skid stage filled while the output was free");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 preset filter. A queue of pixel and drain
// items feeds a valid/ready driver; every accepted item steps a local line
// store and window predictor, and a monitor matches each result item against
// the oldest predicted one. Frames run over many geometries and kernels,
// including zero, saturated and full-width sizes and mid-frame changes.
// ----------------------------------------------------------------------------
module testbench;
  import c3pf_pkg::*;

  localparam int HOLD_OFF   = 16;    // pipeline plus skid stage, with margin
  localparam int STALL_MAX  = 2000;  // cycles without any accepted item
  localparam int RANDOM_LEN = 1050;
  localparam int BIG_PART   = 48;    // items fed at each size extreme
  localparam logic [MODE_W-1:0] MODE_TOP_CODE = 3'd7;  // unused code, acts as box

  localparam int GAUSS_TAPS [9]   = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
  localparam int EMBOSS_TAPS [9]  = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};
  localparam int SHARPEN_TAPS [9] = '{0, -1, 0, -1, 5, -1, 0, -1, 0};

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] pixel;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             is_last;
  } filt_out_t;

  typedef enum {
    FRAME_CLEAN, FRAME_EARLY_DRAIN, FRAME_PIXEL_IN_DRAIN,
    FRAME_MODE_SWAP, FRAME_RESIZE, FRAME_NOISE
  } frame_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  c3pf_in_if  pix_ch ();
  c3pf_out_if res_ch ();

  conv3x3_preset_filter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .results   (res_ch)
  );

  always #2 clk = ~clk;

  pix_item_t feed_q [$];
  filt_out_t filtered_q [$];
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int results_seen;
  int random_items;
  bit counting;

  // predictor state
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [MODE_W-1:0]       mode_reg;
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] lower_line [MAX_WIDTH];
  logic [PIX_W-1:0] taps [3][3];  // [row][column], column 2 newest
  int unsigned in_col, in_row, out_col, out_row;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic int tap_weight(input logic [MODE_W-1:0] mode, input int idx);
    case (mode)
      MODE_GAUSS:   return GAUSS_TAPS[idx];
      MODE_OUTLINE: return (idx == 4) ? 8 : -1;
      MODE_EMBOSS:  return EMBOSS_TAPS[idx];
      MODE_SHARPEN: return SHARPEN_TAPS[idx];
      default:      return 1;
    endcase
  endfunction

  // One accepted item: shift line stores and window, and queue the result
  // for the pixel W+1 positions back, if this item completes one.
  function automatic void filter_step(input logic op, input logic [PIX_W-1:0] pix_in);
    int unsigned w, h;
    logic [PIX_W-1:0] pix, top, mid;
    bit emit;
    int acc, res;
    filt_out_t item;
    w = eff_width();
    h = eff_height();
    pix = (op == OP_PIXEL) ? pix_in : '0;
    top = upper_line[in_col];
    mid = lower_line[in_col];
    upper_line[in_col] = mid;
    lower_line[in_col] = pix;
    for (int r = 0; r < 3; r++) begin
      taps[r][0] = taps[r][1];
      taps[r][1] = taps[r][2];
    end
    taps[0][2] = top;
    taps[1][2] = mid;
    taps[2][2] = pix;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;

    acc = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        // neighbors outside the frame count as zero
        if ((r == 0 && out_row == 0) || (r == 2 && out_row + 1 >= h) ||
            (c == 0 && out_col == 0) || (c == 2 && out_col + 1 >= w)) continue;
        acc += tap_weight(mode_reg, r * 3 + c) * int'(taps[r][c]);
      end
    end
    case (mode_reg)
      MODE_GAUSS:                             res = (acc + 8) / 16;
      MODE_OUTLINE, MODE_EMBOSS, MODE_SHARPEN: res = acc;
      default:                                res = (acc + 4) / 9;
    endcase
    if (res < 0) res = 0;
    if (res > PIX_MAX) res = PIX_MAX;
    item.pixel = PIX_W'(res);
    item.is_last = (out_row + 1 >= h) && (out_col + 1 >= w);
    filtered_q.push_back(item);
    if (item.is_last) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin : drive
    pix_item_t nxt;
    logic send;
    if (rst) begin
      pix_ch.valid <= 1'b0;
      pix_ch.op <= OP_PIXEL;
      pix_ch.pixel_in <= '0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (pix_ch.valid) filter_step(pix_ch.op, pix_ch.pixel_in);
      send = (feed_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
      if (send) begin
        nxt = feed_q.pop_front();
        pix_ch.op <= nxt.op;
        pix_ch.pixel_in <= nxt.pixel;
      end
      pix_ch.valid <= send;
    end
  end

  // --------------------------------------------------------------- monitor
  always @(posedge clk) begin : observe
    filt_out_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (filtered_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d unexpected: pixel_out=%0d frame_last=%0b",
                     results_seen, res_ch.pixel_out, res_ch.frame_last);
        end else begin
          want = filtered_q.pop_front();
          if (res_ch.pixel_out !== want.pixel || res_ch.frame_last !== want.is_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
                       results_seen, want.pixel, res_ch.pixel_out,
                       want.is_last, res_ch.frame_last);
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // -------------------------------------------------------------- watchdog
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_MAX) begin
      @(posedge clk);
      if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // -------------------------------------------------------------- stimulus
  task automatic put(input logic op, input logic [PIX_W-1:0] value);
    pix_item_t it;
    it.op = op;
    it.pixel = value;
    feed_q.push_back(it);
    if (counting) random_items++;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 30) return 8'hFF;
    return PIX_W'($urandom_range(255));
  endfunction

  // wait until the block has taken every item and returned every result
  task automatic settle();
    while (feed_q.size() != 0 || pix_ch.valid || filtered_q.size() != 0)
      @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = value[WIDTH_REG_W-1:0];
        restart_frame();
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = value[HEIGHT_REG_W-1:0];
        restart_frame();
      end
      REG_KERNEL_MODE: mode_reg = value[MODE_W-1:0];
      default: ;
    endcase
  endtask

  // one frame at the current geometry: pixels then W+1 drains, with variations
  task automatic feed_frame(input frame_style_t style);
    int unsigned w, h, npix, total, cut, split;
    w = eff_width();
    h = eff_height();
    npix = w * h;
    total = npix + w + 1;
    cut = (style == FRAME_EARLY_DRAIN) ? $urandom_range(npix - 1, 0) : npix;
    split = $urandom_range(total - 1, 1);
    for (int unsigned k = 0; k < total; k++) begin
      if (k == split && style == FRAME_MODE_SWAP) begin
        settle();
        write_reg(REG_KERNEL_MODE, $urandom_range(7));
      end
      if (k == split && style == FRAME_RESIZE) begin
        settle();
        if ($urandom_range(1) == 1)
          write_reg(REG_IMAGE_WIDTH, $urandom_range(8, 1));
        else
          write_reg(REG_IMAGE_HEIGHT, $urandom_range(6, 1));
        return;
      end
      if (style == FRAME_NOISE)
        put(($urandom_range(1) == 1) ? OP_DRAIN : OP_PIXEL, PIX_W'($urandom_range(255)));
      else if (k < cut)
        put(OP_PIXEL, rand_pixel());
      else if (k >= npix && style == FRAME_PIXEL_IN_DRAIN && $urandom_range(99) < 40)
        put(OP_PIXEL, PIX_W'($urandom_range(255)));
      else
        put(OP_DRAIN, PIX_W'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int unsigned r, wv, hv;
    int big_next;
    frame_style_t style;

    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    mode_reg = MODE_BOX;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) taps[i][j] = '0;
    restart_frame();
    mismatches = 0;
    results_seen = 0;
    random_items = 0;
    counting = 0;
    send_idle_pct = 35;
    recv_idle_pct = 60;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero sizes read as a 1x1 frame
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    write_reg(REG_KERNEL_MODE, MODE_BOX);
    put(OP_PIXEL, 8'hFF);
    put(OP_DRAIN, 8'h00);
    put(OP_DRAIN, 8'hFF);
    settle();

    // 2x2 outline, a pixel item slipped in among the drains
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 2);
    write_reg(REG_KERNEL_MODE, MODE_OUTLINE);
    put(OP_PIXEL, 8'hFF);
    put(OP_PIXEL, 8'h00);
    put(OP_PIXEL, 8'h00);
    put(OP_PIXEL, 8'hFF);
    put(OP_DRAIN, 8'h00);
    put(OP_PIXEL, 8'hFF);
    put(OP_DRAIN, 8'hFF);
    settle();

    // sharpen, early drain, then emboss from the next result on
    write_reg(REG_KERNEL_MODE, MODE_SHARPEN);
    put(OP_PIXEL, 8'h00);
    put(OP_PIXEL, 8'hFF);
    put(OP_DRAIN, 8'hFF);
    settle();
    write_reg(REG_KERNEL_MODE, MODE_EMBOSS);
    put(OP_PIXEL, 8'hFF);
    put(OP_DRAIN, 8'h00);
    put(OP_DRAIN, 8'h00);
    put(OP_DRAIN, 8'h00);
    settle();

    // width change mid-frame restarts it; unused mode code acts as box
    write_reg(REG_KERNEL_MODE, MODE_GAUSS);
    put(OP_PIXEL, 8'hFF);
    put(OP_PIXEL, 8'hFF);
    settle();
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_KERNEL_MODE, MODE_TOP_CODE);
    put(OP_PIXEL, 8'hFF);
    put(OP_PIXEL, 8'h00);
    put(OP_DRAIN, 8'h00);
    put(OP_DRAIN, 8'hFF);

    counting = 1;
    big_next = 0;
    while (random_items < RANDOM_LEN) begin
      if (random_items >= 700) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_items >= 350) begin
        send_idle_pct = 60;
        recv_idle_pct = 35;
      end

      // a partial frame at each size extreme, cut short by a restart
      if (big_next < 3 && random_items >= 150 + 350 * big_next) begin
        settle();
        case (big_next)
          0: begin
            write_reg(REG_IMAGE_WIDTH, 4095);
            write_reg(REG_IMAGE_HEIGHT, 1);
          end
          1: begin
            write_reg(REG_IMAGE_WIDTH, MAX_WIDTH);
            write_reg(REG_IMAGE_HEIGHT, 2);
          end
          default: begin
            write_reg(REG_IMAGE_WIDTH, 1);
            write_reg(REG_IMAGE_HEIGHT, 8191);
          end
        endcase
        write_reg(REG_KERNEL_MODE, $urandom_range(4));
        repeat (BIG_PART) put(OP_PIXEL, rand_pixel());
        settle();
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 3);
        big_next++;
      end

      settle();
      if ($urandom_range(99) < 80) begin
        r = $urandom_range(99);
        if (r < 6) wv = 0;
        else if (r < 12) wv = $urandom_range(40, 12);
        else wv = $urandom_range(8, 1);
        r = $urandom_range(99);
        if (wv <= 3 && r < 25) hv = $urandom_range(24, 10);
        else if (r < 31) hv = 0;
        else hv = $urandom_range(6, 1);
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
      end
      if ($urandom_range(99) < 70)
        write_reg(REG_KERNEL_MODE, $urandom_range((1 << CFG_DATA_W) - 1));

      r = $urandom_range(99);
      if (r < 55) style = FRAME_CLEAN;
      else if (r < 67) style = FRAME_EARLY_DRAIN;
      else if (r < 77) style = FRAME_PIXEL_IN_DRAIN;
      else if (r < 87) style = FRAME_MODE_SWAP;
      else if (r < 93) style = FRAME_RESIZE;
      else style = FRAME_NOISE;
      feed_frame(style);
    end

    counting = 0;
    settle();
    if (mismatches == 0 && filtered_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
